@@ rtl/x86bcu_pkg.sv @@
// ----------------------------------------------------------------------------
// x86bcu_pkg
// Shared types and constants of the x86 branch/call target unfilter.
// ----------------------------------------------------------------------------
package x86bcu_pkg;

    localparam int WIN_DEPTH             = 6;
    localparam int HOLD_DEPTH            = WIN_DEPTH - 1;
    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int MAX_EMIT              = 6;
    localparam int OQ_DEPTH              = 8;
    localparam int OQ_AW                 = $clog2(OQ_DEPTH);
    localparam int OQ_LW                 = $clog2(OQ_DEPTH + 1);

    localparam logic [7:0] OP_CALL = 8'hE8;
    localparam logic [7:0] OP_JMP  = 8'hE9;
    localparam logic [7:0] OP_ESC  = 8'h0F;
    localparam logic [7:0] JCC_LO  = 8'h80;
    localparam logic [7:0] JCC_HI  = 8'h8F;

    localparam logic [31:0] BIAS_REL = 32'd5;
    localparam logic [31:0] BIAS_JCC = 32'd6;
    localparam logic [2:0]  SKIP_REL = 3'd4;
    localparam logic [2:0]  SKIP_JCC = 3'd5;

    typedef logic [7:0] byte_t;
    typedef byte_t [WIN_DEPTH-1:0] window_t;
    typedef byte_t [HOLD_DEPTH-1:0] hold_t;

    typedef struct packed {
        window_t    win;
        logic [2:0] skip;
    } scan_result_t;

    typedef struct packed {
        byte_t data;
        logic  last;
    } out_entry_t;

    typedef struct packed {
        logic [2:0]                  count;
        out_entry_t [MAX_EMIT-1:0]   entry;
    } push_t;

endpackage

@@ rtl/x86bcu_fix.sv @@
// ----------------------------------------------------------------------------
// x86bcu_fix
// Opcode scan and operand rewrite on the six-byte look-ahead window.
// ----------------------------------------------------------------------------
module x86bcu_fix
    import x86bcu_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  window_t                  win,
    input  byte_t                    marker,
    input  logic [POSITION_BITS-1:0] position,
    input  logic [2:0]               skip,
    output scan_result_t             result
);

    logic        is_rel;
    logic        is_jcc;
    logic        hit;
    byte_t       b0, b1, b2, b3;
    logic [31:0] operand;
    logic [31:0] subtrahend;
    logic [31:0] value;

    always_comb
    begin
        is_rel = (win[0] == OP_CALL) || (win[0] == OP_JMP);
        is_jcc = (win[0] == OP_ESC) && (win[1] >= JCC_LO) && (win[1] <= JCC_HI);

        // operand starts one byte after e8/e9, two bytes after 0f 8x
        b0 = is_rel ? win[1] : win[2];
        b1 = is_rel ? win[2] : win[3];
        b2 = is_rel ? win[3] : win[4];
        b3 = is_rel ? win[4] : win[5];

        if (marker == 8'h00)
        begin
            operand    = {b3, b2, b1, b0};
            subtrahend = 32'(position);
            hit        = 1'b1;
        end
        else
        begin
            // marker mode: big-endian 24-bit value after the marker
            operand    = {8'h00, b1, b2, b3};
            subtrahend = 32'(position) + (is_rel ? BIAS_REL : BIAS_JCC);
            hit        = (b0 == marker);
        end
        value = operand - subtrahend;

        result.win  = win;
        result.skip = skip;
        if (skip != 3'd0)
        begin
            result.skip = skip - 3'd1;
        end
        else if (is_rel)
        begin
            result.skip = SKIP_REL;
            if (hit)
            begin
                result.win[1] = value[7:0];
                result.win[2] = value[15:8];
                result.win[3] = value[23:16];
                result.win[4] = value[31:24];
            end
        end
        else if (is_jcc)
        begin
            result.skip = SKIP_JCC;
            if (hit)
            begin
                result.win[2] = value[7:0];
                result.win[3] = value[15:8];
                result.win[4] = value[23:16];
                result.win[5] = value[31:24];
            end
        end
    end

endmodule

@@ rtl/x86bcu_outq.sv @@
// ----------------------------------------------------------------------------
// x86bcu_outq
// Result queue: takes up to six bytes a cycle, hands out one per transaction.
// ----------------------------------------------------------------------------
module x86bcu_outq
    import x86bcu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  push_t            push,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic             m_tlast,   // out_end
    output logic [OQ_LW-1:0] level
);

    out_entry_t       mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_LW-1:0] level_reg, level_next;
    logic             pop;

    assign m_tvalid = (level_reg != '0);
    assign m_tdata  = mem_reg[rd_ptr_reg].data;
    assign m_tlast  = mem_reg[rd_ptr_reg].last;
    assign level    = level_reg;
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OQ_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + OQ_AW'(pop);
        level_next  = level_reg + OQ_LW'(push.count) - OQ_LW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_EMIT; i++)
        begin
            if (3'(i) < push.count)
            begin
                mem_reg[wr_ptr_reg + OQ_AW'(i)] <= push.entry[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

@@ rtl/x86_branch_call_unfilter.sv @@
// scan: a byte is scanned and queued once five later bytes of its block are in,
//   or at once when its block ends; the result queue that it enters is registered
// throughput: one byte per cycle; input pauses until the result queue is down to two
//   entries; at block end up to six bytes go out one per cycle as m_tready allows
// reset: clears fill, position, skip count, marker and the result queue
// ----------------------------------------------------------------------------
// x86_branch_call_unfilter
// Undoes the e8/e9 and 0f 8x branch-target filter on a streamed x86 code block.
// ----------------------------------------------------------------------------
module x86_branch_call_unfilter
    import x86bcu_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // code_byte
    input  logic       s_tlast,    // block_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic       m_tlast,    // out_end
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata   // marker_byte
);

    hold_t                    hold_reg, hold_next;
    logic [2:0]               fill_reg, fill_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [2:0]               skip_reg, skip_next;
    byte_t                    marker_reg;

    window_t                  win_in;
    window_t                  win_emit;
    scan_result_t             scan;
    push_t                    push;
    logic                     full;
    logic                     accept;
    logic [OQ_LW-1:0]         oq_level;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (oq_level <= OQ_LW'(OQ_DEPTH - MAX_EMIT));
    assign full     = (fill_reg == 3'(HOLD_DEPTH));

    always_comb
    begin
        win_in           = {8'h00, hold_reg};
        win_in[fill_reg] = s_tdata;
        win_emit         = full ? scan.win : win_in;
    end

    x86bcu_fix #(
        .POSITION_BITS (POSITION_BITS)
    ) u_fix (
        .win      (win_in),
        .marker   (marker_reg),
        .position (pos_reg),
        .skip     (skip_reg),
        .result   (scan)
    );

    always_comb
    begin
        if (!accept)
        begin
            push.count = 3'd0;
        end
        else if (s_tlast)
        begin
            push.count = full ? 3'(MAX_EMIT) : fill_reg + 3'd1;
        end
        else
        begin
            push.count = full ? 3'd1 : 3'd0;
        end
        for (int i = 0; i < MAX_EMIT; i++)
        begin
            push.entry[i].data = win_emit[i];
            push.entry[i].last = s_tlast && (3'(i) == push.count - 3'd1);
        end
    end

    always_comb
    begin
        hold_next = hold_reg;
        fill_next = fill_reg;
        pos_next  = pos_reg;
        skip_next = skip_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                fill_next = 3'd0;
                pos_next  = '0;
                skip_next = 3'd0;
            end
            else if (full)
            begin
                hold_next = scan.win[WIN_DEPTH-1:1];
                skip_next = scan.skip;
                // position saturates at all ones
                pos_next  = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
            end
            else
            begin
                hold_next = win_in[HOLD_DEPTH-1:0];
                fill_next = fill_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 3'd0;
            pos_reg    <= '0;
            skip_reg   <= 3'd0;
            marker_reg <= 8'h00;
        end
        else
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
            skip_reg <= skip_next;
            if (cfg_we)
            begin
                marker_reg <= cfg_wdata;
            end
        end
    end

    x86bcu_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .level    (oq_level)
    );

`ifndef NO_ASSERTIONS
    a_block_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (fill_reg == 3'd0 && skip_reg == 3'd0 && pos_reg == '0))
        else $error("block state not cleared after last transaction");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_level <= OQ_LW'(OQ_DEPTH))
        else $error("result queue overflow");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= 3'(HOLD_DEPTH)) && (skip_reg <= SKIP_JCC))
        else $error("window fill or skip count out of range");

    a_skip_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_reg != 3'd0) |-> (fill_reg == 3'(HOLD_DEPTH)))
        else $error("skip count set while window not full");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the x86 branch/call target unfilter. Code blocks
// are streamed in byte by byte with random gaps and output stalls. Each
// accepted byte runs through an in-bench look-ahead window that predicts
// the restored bytes; these, or the expected bytes of a directed row,
// are compared with the output stream in order. A short table of directed
// blocks is followed by random blocks under several marker settings.
// ----------------------------------------------------------------------------
module tb;
    import x86bcu_pkg::*;

    localparam int          POS_BITS = POSITION_BITS_DEFAULT;
    localparam logic [31:0] POS_MAX  = 32'hFFFF_FFFF >> (32 - POS_BITS);
    localparam int          DRAIN_WAIT = 8;

    typedef struct packed {
        logic        wr_marker;
        logic [7:0]  val;
        logic        last;
        logic        known;
        logic [2:0]  n_known;
        logic [47:0] known_out;   // expected bytes, first one lowest
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;

    // predictor state
    logic [7:0]  pw [0:WIN_DEPTH-1];
    int          pw_fill;
    logic [31:0] pw_pos;
    int          pw_skip;
    logic [7:0]  marker_reg;

    out_entry_t  fresh_q [$];
    out_entry_t  restored_q [$];
    logic [7:0]  pend [$];
    dir_row_t    dir_tab [$];

    bit idle_on = 1'b1;
    int fail_count = 0;
    int bytes_in = 0;
    int blocks_in = 0;
    int results_seen = 0;
    int rel_hits = 0;
    int jcc_hits = 0;
    int rewrites = 0;

    always #5 clk = ~clk;

    x86_branch_call_unfilter #(
        .POSITION_BITS (POS_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    task automatic clear_window();
        for (int i = 0; i < WIN_DEPTH; i++)
            pw[i] = 8'h00;
        pw_fill = 0;
        pw_pos  = 32'd0;
        pw_skip = 0;
    endtask

    task automatic patch_operand(input int k, input logic [31:0] bias);
        logic [31:0] v;
        if (marker_reg == 8'h00)
            v = {pw[k+3], pw[k+2], pw[k+1], pw[k]} - pw_pos;
        else if (pw[k] != marker_reg)
            return;
        else
            v = {8'h00, pw[k+1], pw[k+2], pw[k+3]} - (pw_pos + bias);
        {pw[k+3], pw[k+2], pw[k+1], pw[k]} = v;
        rewrites++;
    endtask

    // one byte into the window; restored bytes it releases go to fresh_q
    task automatic predict_byte(input logic [7:0] val, input logic last);
        fresh_q.delete();
        if (pw_fill > WIN_DEPTH - 1)
            pw_fill = WIN_DEPTH - 1;
        pw[pw_fill] = val;
        pw_fill++;
        if (pw_fill == WIN_DEPTH)
        begin
            if (pw_skip > 0)
                pw_skip--;
            else if (pw[0] == OP_CALL || pw[0] == OP_JMP)
            begin
                patch_operand(1, BIAS_REL);
                pw_skip = SKIP_REL;
                rel_hits++;
            end
            else if (pw[0] == OP_ESC && pw[1] >= JCC_LO && pw[1] <= JCC_HI)
            begin
                patch_operand(2, BIAS_JCC);
                pw_skip = SKIP_JCC;
                jcc_hits++;
            end
            fresh_q.push_back('{data: pw[0], last: 1'b0});
            for (int i = 0; i < WIN_DEPTH - 1; i++)
                pw[i] = pw[i+1];
            pw[WIN_DEPTH-1] = 8'h00;
            pw_fill = WIN_DEPTH - 1;
            if (pw_pos < POS_MAX)
                pw_pos++;
        end
        if (last)
        begin
            // flush unscanned, end flag on the final byte
            for (int i = 0; i < pw_fill; i++)
                fresh_q.push_back('{data: pw[i], last: (i + 1 == pw_fill)});
            clear_window();
        end
    endtask

    task automatic send_item(input logic [7:0] val, input logic last, input logic known,
                             input logic [2:0] n_known, input logic [47:0] known_out);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        predict_byte(val, last);
        bytes_in++;
        if (last)
            blocks_in++;
        if (known)
        begin
            for (int i = 0; i < n_known; i++)
                restored_q.push_back('{data: known_out[8*i +: 8],
                                       last: last && (i + 1 == n_known)});
        end
        else
        begin
            foreach (fresh_q[i])
                restored_q.push_back(fresh_q[i]);
        end
    endtask

    // marker writes only once the output side has drained
    task automatic set_marker(input logic [7:0] mk);
        s_tvalid <= 1'b0;
        while (restored_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mk;
        @(posedge clk);
        cfg_we    <= 1'b0;
        marker_reg = mk;
    endtask

    // append one chunk of code: a branch sequence half the time, else noise
    task automatic fill_run(input logic [7:0] mk);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 4)
        begin
            if (kind <= 2)
                pend.push_back($urandom_range(0, 1) ? OP_CALL : OP_JMP);
            else
            begin
                pend.push_back(OP_ESC);
                pend.push_back(8'($urandom_range(JCC_LO, JCC_HI)));
            end
            pend.push_back((mk != 8'h00 && $urandom_range(0, 3) != 0) ? mk
                                                                      : 8'($urandom_range(0, 255)));
            repeat (3) pend.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 5)
        begin
            // escape byte with a random follower, often not a jcc
            pend.push_back(OP_ESC);
            pend.push_back(8'($urandom_range(0, 255)));
        end
        else
            pend.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic dir_row_t mk_row(input logic wr, input logic [7:0] v, input logic l,
                                        input logic k, input logic [2:0] n,
                                        input logic [47:0] o);
        return {wr, v, l, k, n, o};
    endfunction

    // output side: random stall before each transaction, none when idle_on is clear
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : chk_out
        out_entry_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (restored_q.size() == 0)
            begin
                fail_count++;
                if (fail_count < 40)
                    $display("%0t: unexpected byte, expected none, got data %02h last %0b",
                             $time, m_tdata, m_tlast);
            end
            else
            begin
                want = restored_q.pop_front();
                if (m_tdata !== want.data)
                begin
                    fail_count++;
                    if (fail_count < 40)
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, want.data, m_tdata);
                end
                if (m_tlast !== want.last)
                begin
                    fail_count++;
                    if (fail_count < 40)
                        $display("%0t: out_end mismatch, expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                end
            end
        end
    end

    initial
    begin
        int          len;
        int          cnt;
        logic [7:0]  mk;
        dir_row_t    r;

        clear_window();
        marker_reg = 8'h00;

        // plain mode from reset
        dir_tab.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'hFF, 1'b1, 1'b1, 3'd2, 48'hFF00));
        dir_tab.push_back(mk_row(1'b0, OP_CALL, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h78, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h56, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h34, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h12, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h00, 1'b1, 1'b1, 3'd6, 48'h00_12_34_56_78_E8));
        // jcc at position 1
        dir_tab.push_back(mk_row(1'b0, 8'h90, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, OP_ESC, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, JCC_HI, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h05, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h00, 1'b1, 1'b0, 3'd0, 48'h0));
        // marker changes mid-block: new marker misses, operand kept, still skipped
        dir_tab.push_back(mk_row(1'b1, 8'hAB, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, OP_CALL, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'hAB, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h10, 1'b0, 1'b1, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b1, 8'hCD, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h90, 1'b1, 1'b1, 3'd6, 48'h90_10_00_00_AB_E8));
        // marker at its top value, wrapping result
        dir_tab.push_back(mk_row(1'b1, 8'hFF, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, OP_ESC, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, JCC_LO, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'hFF, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 48'h0));
        dir_tab.push_back(mk_row(1'b0, 8'h02, 1'b1, 1'b0, 3'd0, 48'h0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            r = dir_tab[i];
            if (r.wr_marker)
                set_marker(r.val);
            else
                send_item(r.val, r.last, r.known, r.n_known, r.known_out);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 0 || ph == 4)
                mk = 8'h00;
            else if (ph == 1)
                mk = 8'hFF;
            else if (ph == 2)
                mk = 8'h01;
            else
                mk = 8'($urandom_range(2, 254));
            set_marker(mk);
            idle_on = (ph != 2);
            cnt = 0;
            while (cnt < 56)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 48);
                pend.delete();
                while (pend.size() < len)
                    fill_run(mk);
                for (int j = 0; j < len; j++)
                    send_item(pend[j], j == len - 1, 1'b0, 3'd0, 48'h0);
                cnt += len;
            end
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        while (restored_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d code bytes in %0d blocks, %0d restored bytes checked",
                 bytes_in, blocks_in, results_seen);
        $display("markers 00/FF/01/random; %0d call/jmp and %0d jcc scans, %0d rewrites",
                 rel_hits, jcc_hits, rewrites);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d restored bytes outstanding", restored_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
